[rtl/core/seqrp_pkg.sv]
`timescale 1ns / 1ps

package seqrp_pkg;

    localparam int TRACKS         = 8;
    localparam int TICKS_PER_BEAT = 96;
    localparam int HEADER_BYTES   = 42;

    localparam int TRACK_W = $clog2(TRACKS + 1);
    localparam int REC_MAX = 7;
    localparam int CNT_W   = $clog2(REC_MAX + 1);

    localparam logic [7:0] CODE_PROGRAM    = 8'd122;
    localparam logic [7:0] CODE_AFTERTOUCH = 8'd123;
    localparam logic [7:0] CODE_BEND       = 8'd124;
    localparam logic [7:0] CODE_SYSEX      = 8'd125;
    localparam logic [7:0] CODE_END        = 8'h80;
    localparam logic [7:0] HIGH_BIT        = 8'h80;
    localparam logic [15:0] BEND_CENTER    = 16'd8192;
    localparam logic [15:0] SYSEX2_DURA    = 16'h8000;

    typedef enum logic [3:0] {
        KIND_NOTE       = 4'd0,
        KIND_CTRL       = 4'd1,
        KIND_BEND       = 4'd2,
        KIND_AFTERTOUCH = 4'd3,
        KIND_PROGRAM    = 4'd4,
        KIND_SYSEX3     = 4'd5,
        KIND_SYSEX2     = 4'd6,
        KIND_SYSEX1     = 4'd7,
        KIND_END        = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_ORDER    = 2'd1,
        ERR_END_TIME = 2'd2,
        ERR_BAD      = 2'd3
    } err_t;

    typedef struct packed {
        logic [8*REC_MAX-1:0] bytes;
        logic [CNT_W-1:0]     cnt;
        logic                 byte_ok;
        err_t                 err;
        logic [TRACK_W-1:0]   trk;
        logic [15:0]          offs;
    } rec_t;

endpackage

[rtl/core/sequencer_event_record_packer.sv]
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid / in_stall    kind has_time at_beat at_tick chan val_a val_b
//                                             len_beat len_tick
// out       output     out_valid / out_stall  data_byte byte_valid last error ended_track offset
// cfg       input      cfg_we                 cfg_wdata (part_beats)
//
// An event is packed in the cycle it is accepted and parked in a record register;
// the byte shifter then sends one byte per cycle while out is not stalled, so a timed
// event gives 7 bytes, an untimed one 5 and a rejected one 1 on the single output byte lane.
// The next event is taken while the current record is still being sent.
// Reset: prev_time 0, track count TRACKS, byte offset HEADER_BYTES, both stages empty.
// A stall on out holds the shifter; in stalls only while the record register is full.

module sequencer_event_record_packer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [3:0]                  kind,
    input  logic                        has_time,
    input  logic [9:0]                  at_beat,
    input  logic [6:0]                  at_tick,
    input  logic [7:0]                  chan,
    input  logic [15:0]                 val_a,
    input  logic [7:0]                  val_b,
    input  logic [9:0]                  len_beat,
    input  logic [6:0]                  len_tick,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  data_byte,
    output logic                        byte_valid,
    output logic                        last,
    output logic [1:0]                  error,
    output logic [seqrp_pkg::TRACK_W-1:0] ended_track,
    output logic [15:0]                 offset,
    input  logic                        cfg_we,
    input  logic [9:0]                  cfg_wdata
);
    import seqrp_pkg::*;

    localparam logic [15:0] TPB16 = 16'(TICKS_PER_BEAT);
    localparam logic [TRACK_W-1:0] TRACKS_V = TRACK_W'(TRACKS);
    localparam logic [15:0] HEADER_V = 16'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [9:0]         part_beats_reg;
    logic [15:0]        prev_time_reg, prev_time_next;
    logic [TRACK_W-1:0] track_left_reg, track_left_next;
    logic [15:0]        byte_offset_reg, byte_offset_next;

    rec_t               rec_reg, rec_next;
    logic               rec_valid_reg, rec_valid_next;
    rec_t               sh_reg, sh_next;

    logic               accept, take, ser_done, ser_load;
    logic [15:0]        when_t, dur_t, end_t, bend_v, dura;
    logic [7:0]         code, amount, chb;
    logic               bad;
    logic [CNT_W-1:0]   n;
    logic [16:0]        off_sum;
    logic [15:0]        off_sat;
    err_t               err;

    assign out_valid = (sh_reg.cnt != '0);
    assign take      = out_valid && !out_stall;
    assign ser_done  = take && (sh_reg.cnt == CNT_ONE);
    assign ser_load  = rec_valid_reg && (!out_valid || ser_done);
    assign in_stall  = rec_valid_reg && !ser_load;
    assign accept    = in_valid && !in_stall;

    assign data_byte   = sh_reg.bytes[7:0];
    assign byte_valid  = sh_reg.byte_ok;
    assign last        = (sh_reg.cnt == CNT_ONE);
    assign error       = sh_reg.err;
    assign ended_track = sh_reg.trk;
    assign offset      = sh_reg.offs;

    always_comb
    begin
        when_t = 16'({6'd0, at_beat} * TPB16 + {9'd0, at_tick});
        dur_t  = 16'({6'd0, len_beat} * TPB16 + {9'd0, len_tick});
        end_t  = 16'({6'd0, part_beats_reg} * TPB16);
        bend_v = val_a + BEND_CENTER;
        bad    = (kind > KIND_END) || ((kind == KIND_END) && !has_time);

        code   = '0;
        amount = '0;
        chb    = {4'd0, 4'(chan[3:0] - 4'd1)};
        dura   = '0;
        case (kind)
            KIND_NOTE:
            begin
                code   = {1'b0, val_a[6:0]};
                amount = {1'b0, val_b[6:0]};
                dura   = {dur_t[7:0], dur_t[15:8]};
            end
            KIND_CTRL:
            begin
                code   = {1'b0, val_a[6:0]};
                amount = val_b | HIGH_BIT;
            end
            KIND_BEND:
            begin
                code   = CODE_BEND;
                amount = HIGH_BIT;
                dura   = {1'b0, bend_v[13:7], 1'b0, bend_v[6:0]};
            end
            KIND_AFTERTOUCH:
            begin
                code   = CODE_AFTERTOUCH;
                amount = val_a[7:0] | HIGH_BIT;
            end
            KIND_PROGRAM:
            begin
                code   = CODE_PROGRAM;
                amount = val_a[7:0] | HIGH_BIT;
            end
            KIND_SYSEX3:
            begin
                code   = CODE_SYSEX;
                amount = chan | HIGH_BIT;
                chb    = {1'b0, val_a[6:0]};
                dura   = {1'b0, val_b[6:0], 8'd0};
            end
            KIND_SYSEX2:
            begin
                code   = CODE_SYSEX;
                amount = chan | HIGH_BIT;
                chb    = {1'b0, val_a[6:0]};
                dura   = SYSEX2_DURA;
            end
            KIND_SYSEX1:
            begin
                code   = CODE_SYSEX;
                amount = chan | HIGH_BIT;
                chb    = HIGH_BIT;
            end
            default:
            begin
                code = CODE_END;
                chb  = CODE_END;
            end
        endcase

        n       = has_time ? CNT_W'(7) : CNT_W'(5);
        off_sum = {1'b0, byte_offset_reg} + {{(17-CNT_W){1'b0}}, n};
        off_sat = off_sum[16] ? 16'hFFFF : off_sum[15:0];

        prev_time_next   = prev_time_reg;
        track_left_next  = track_left_reg;
        byte_offset_next = byte_offset_reg;
        err              = ERR_OK;

        rec_next          = rec_reg;
        rec_next.byte_ok  = 1'b1;
        rec_next.trk      = '0;
        rec_next.offs     = '0;
        rec_next.cnt      = n;
        if (has_time)
            rec_next.bytes = {dura[15:8], dura[7:0], chb, amount,
                              when_t[15:8], when_t[7:0], code | HIGH_BIT};
        else
            rec_next.bytes = {16'd0, dura[15:8], dura[7:0], chb, amount, code};

        if (bad)
        begin
            rec_next.bytes   = '0;
            rec_next.cnt     = CNT_ONE;
            rec_next.byte_ok = 1'b0;
            err              = ERR_BAD;
        end
        else
        begin
            byte_offset_next = off_sat;
            if (kind == KIND_END)
            begin
                prev_time_next = '0;
                rec_next.trk   = track_left_reg;
                rec_next.offs  = off_sat;
                if (end_t != when_t)
                    err = ERR_END_TIME;
                if (track_left_reg > TRACK_W'(1))
                    track_left_next = track_left_reg - TRACK_W'(1);
                else
                begin
                    track_left_next  = TRACKS_V;
                    byte_offset_next = HEADER_V;
                end
            end
            else if (has_time)
            begin
                if ((prev_time_reg != '0) && (when_t <= prev_time_reg))
                    err = ERR_ORDER;
                prev_time_next = when_t;
            end
        end
        rec_next.err = err;

        rec_valid_next = accept ? 1'b1 : (ser_load ? 1'b0 : rec_valid_reg);

        sh_next = sh_reg;
        if (ser_load)
            sh_next = rec_reg;
        else if (take)
        begin
            sh_next.bytes = {8'd0, sh_reg.bytes[8*REC_MAX-1:8]};
            sh_next.cnt   = sh_reg.cnt - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_beats_reg  <= '0;
            prev_time_reg   <= '0;
            track_left_reg  <= TRACKS_V;
            byte_offset_reg <= HEADER_V;
            rec_valid_reg   <= 1'b0;
            sh_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
                part_beats_reg <= cfg_wdata;
            if (accept)
            begin
                prev_time_reg   <= prev_time_next;
                track_left_reg  <= track_left_next;
                byte_offset_reg <= byte_offset_next;
            end
            rec_valid_reg <= rec_valid_next;
            sh_reg        <= sh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rec_reg <= rec_next;
    end

    // a record is never cut short once it starts
    a_record_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> out_valid)
        else $error("record broken before last byte");

    // taking an item into a full record register needs the shifter to drain it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rec_valid_reg) |-> ser_load)
        else $error("pending record overwritten");

    // a rejected item is a single empty result
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (last && (error == ERR_BAD) && (data_byte == 8'd0)))
        else $error("rejected item result malformed");

    // track and offset are reported only on end records
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (ended_track == '0)) |-> (offset == 16'd0))
        else $error("offset reported outside an end record");

endmodule
